// ===== sv/i2cms_pkg.sv =====
package i2cms_pkg;

    localparam int HOLD_WIDTH = 16;
    localparam int TPS_WIDTH  = 16;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [TPS_WIDTH-1:0] TPS_RESET = 16'd50;
    localparam logic [32:0] HOLD_MAX = (33'd1 << HOLD_WIDTH) - 33'd1;

    // register index taken from the word address
    localparam logic REG_TICKS_PER_STEP = 1'b0;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_SEND   = 3'd2,
        OP_RECV   = 3'd3,
        OP_ACK_TX = 3'd4,
        OP_ACK_RX = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ACT_SDA_HI,
        ACT_SDA_LO,
        ACT_SCL_HI,
        ACT_SCL_LO,
        ACT_SDA_BIT,
        ACT_SAMPLE_RX,
        ACT_SAMPLE_ACK
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [2:0] pos;
    } step_t;

    // one word of the queue between front and back
    typedef struct packed {
        logic       cmd;
        logic [2:0] op;
        logic [7:0] tx;
        logic       ack;
        logic       sda;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // bit number and phase of a three-step bit slot
    localparam logic [2:0] DIV3 [0:31] = '{
        3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
        3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5,
        3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };
    localparam logic [1:0] MOD3 [0:31] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };

    function automatic logic [4:0] seq_len(input op_t op);
        logic [4:0] n;
        unique case (op)
            OP_START:  n = 5'd4;
            OP_STOP:   n = 5'd3;
            OP_SEND:   n = 5'd26;
            OP_RECV:   n = 5'd27;
            OP_ACK_TX: n = 5'd3;
            OP_ACK_RX: n = 5'd4;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic step_t step_decode(input op_t op, input logic [4:0] idx);
        step_t      s;
        logic [4:0] j;
        s.act = ACT_SCL_LO;
        s.pos = 3'd0;
        j     = idx - 5'd1;
        unique case (op)
            OP_START:
            begin
                if (idx == 5'd0)      s.act = ACT_SDA_HI;
                else if (idx == 5'd1) s.act = ACT_SCL_HI;
                else if (idx == 5'd2) s.act = ACT_SDA_LO;
                else                  s.act = ACT_SCL_LO;
            end
            OP_STOP:
            begin
                if (idx == 5'd0)      s.act = ACT_SDA_LO;
                else if (idx == 5'd1) s.act = ACT_SCL_HI;
                else                  s.act = ACT_SDA_HI;
            end
            OP_SEND:
            begin
                if (idx < 5'd24)
                begin
                    s.pos = DIV3[idx];
                    unique case (MOD3[idx])
                        2'd0:    s.act = ACT_SDA_BIT;
                        2'd1:    s.act = ACT_SCL_HI;
                        default: s.act = ACT_SCL_LO;
                    endcase
                end
                else if (idx == 5'd24) s.act = ACT_SCL_LO;
                else                   s.act = ACT_SDA_HI;
            end
            OP_RECV:
            begin
                if (idx == 5'd0) s.act = ACT_SDA_HI;
                else if (idx <= 5'd24)
                begin
                    s.pos = DIV3[j];
                    unique case (MOD3[j])
                        2'd0:    s.act = ACT_SCL_HI;
                        2'd1:    s.act = ACT_SAMPLE_RX;
                        default: s.act = ACT_SCL_LO;
                    endcase
                end
                else if (idx == 5'd25) s.act = ACT_SCL_LO;
                else                   s.act = ACT_SDA_HI;
            end
            OP_ACK_TX:
            begin
                if (idx == 5'd0)      s.act = ACT_SDA_BIT;
                else if (idx == 5'd1) s.act = ACT_SCL_HI;
                else                  s.act = ACT_SCL_LO;
            end
            default:
            begin
                if (idx == 5'd0)      s.act = ACT_SDA_HI;
                else if (idx == 5'd1) s.act = ACT_SCL_HI;
                else if (idx == 5'd2) s.act = ACT_SAMPLE_ACK;
                else                  s.act = ACT_SCL_LO;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== sv/i2cms_front.sv =====
module i2cms_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command_valid,
    input  logic [2:0]          operation,
    input  logic [7:0]          tx_byte,
    input  logic                ack_to_send,
    input  logic                sda_line,
    output i2cms_pkg::q_head_t  head,
    input  logic                pop
);

    i2cms_pkg::item_t            mem_reg [i2cms_pkg::QDEPTH];
    logic [i2cms_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [i2cms_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [i2cms_pkg::QCNT_W-1:0] count_reg, count_next;
    i2cms_pkg::item_t            in_item;
    logic                        push;
    logic                        do_pop;

    assign in_ready = (count_reg < i2cms_pkg::QCNT_W'(i2cms_pkg::QDEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    // classify: only a command with a meaningful operation starts a sequence
    always_comb
    begin
        in_item.cmd = command_valid && (operation <= 3'(i2cms_pkg::OP_ACK_RX));
        in_item.op  = operation;
        in_item.tx  = tx_byte;
        in_item.ack = ack_to_send;
        in_item.sda = sda_line;
    end

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

// ===== sv/i2cms_back.sv =====
module i2cms_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  i2cms_pkg::q_head_t                  head,
    output logic                                pop,
    input  logic [i2cms_pkg::TPS_WIDTH-1:0]     ticks_per_step,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                scl_level,
    output logic                                sda_level,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [7:0]                          rx_byte,
    output logic                                ack_seen
);

    logic                                active_reg, active_next;
    i2cms_pkg::op_t                      op_reg, op_next;
    logic [4:0]                          idx_reg, idx_next;
    logic [i2cms_pkg::HOLD_WIDTH-1:0]    hold_reg, hold_next;
    logic [7:0]                          tx_reg, tx_next;
    logic [7:0]                          rx_reg, rx_next;
    logic                                scl_reg, scl_next;
    logic                                sda_reg, sda_next;
    logic                                ack_reg, ack_next;
    logic                                done_reg, done_next;
    logic                                out_valid_reg;

    logic                                fire;
    logic                                do_step;
    i2cms_pkg::op_t                      s_op;
    logic [4:0]                          s_idx;
    logic [4:0]                          idx_inc;
    logic [7:0]                          s_tx;
    i2cms_pkg::step_t                    st;
    logic [i2cms_pkg::TPS_WIDTH-1:0]     tps_m1;
    logic [i2cms_pkg::HOLD_WIDTH-1:0]    reload;

    // state moves only when the output register can take the word
    assign fire = head.valid && (!out_valid_reg || out_ready);
    assign pop  = fire;

    // zero counts as one; clamp to the hold counter range
    always_comb
    begin
        tps_m1 = (ticks_per_step == '0) ? '0 : ticks_per_step - 1'b1;
        if (33'(tps_m1) > i2cms_pkg::HOLD_MAX)
            reload = i2cms_pkg::HOLD_WIDTH'(i2cms_pkg::HOLD_MAX);
        else
            reload = i2cms_pkg::HOLD_WIDTH'(tps_m1);
    end

    always_comb
    begin
        active_next = active_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        tx_next     = tx_reg;
        rx_next     = rx_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        ack_next    = ack_reg;
        done_next   = 1'b0;
        do_step     = 1'b0;
        s_op        = op_reg;
        s_idx       = idx_reg;
        s_tx        = tx_reg;
        idx_inc     = idx_reg + 5'd1;
        if (fire)
        begin
            if (active_reg)
            begin
                if (hold_reg != '0)
                    hold_next = hold_reg - 1'b1;
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc >= i2cms_pkg::seq_len(op_reg))
                    begin
                        active_next = 1'b0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        do_step = 1'b1;
                        s_idx   = idx_inc;
                    end
                end
            end
            else if (head.item.cmd)
            begin
                active_next = 1'b1;
                op_next     = i2cms_pkg::op_t'(head.item.op);
                idx_next    = 5'd0;
                if (op_next == i2cms_pkg::OP_ACK_TX)
                    tx_next = {head.item.ack, 7'd0};
                else if (op_next == i2cms_pkg::OP_SEND)
                    tx_next = head.item.tx;
                if (op_next == i2cms_pkg::OP_RECV)
                    rx_next = 8'd0;
                do_step = 1'b1;
                s_op    = op_next;
                s_idx   = 5'd0;
                s_tx    = tx_next;
            end
        end
        st = i2cms_pkg::step_decode(s_op, s_idx);
        if (do_step)
        begin
            hold_next = reload;
            unique case (st.act)
                i2cms_pkg::ACT_SDA_HI:     sda_next = 1'b1;
                i2cms_pkg::ACT_SDA_LO:     sda_next = 1'b0;
                i2cms_pkg::ACT_SCL_HI:     scl_next = 1'b1;
                i2cms_pkg::ACT_SCL_LO:     scl_next = 1'b0;
                i2cms_pkg::ACT_SDA_BIT:    sda_next = s_tx[3'd7 - st.pos];
                i2cms_pkg::ACT_SAMPLE_RX:
                begin
                    if (head.item.sda)
                        rx_next[3'd7 - st.pos] = 1'b1;
                end
                i2cms_pkg::ACT_SAMPLE_ACK: ack_next = head.item.sda;
                default:                   scl_next = scl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            op_reg        <= i2cms_pkg::OP_START;
            idx_reg       <= '0;
            hold_reg      <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            op_reg     <= op_next;
            idx_reg    <= idx_next;
            hold_reg   <= hold_next;
            tx_reg     <= tx_next;
            rx_reg     <= rx_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            ack_reg    <= ack_next;
            if (fire)
                done_reg <= done_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // state only advances on a load, so it doubles as the output payload
    assign out_valid = out_valid_reg;
    assign scl_level = scl_reg;
    assign sda_level = sda_reg;
    assign busy_res  = active_reg;
    assign done_res  = done_reg;
    assign rx_byte   = rx_reg;
    assign ack_seen  = ack_reg;

endmodule

// ===== sv/i2c_master_bit_sequencer_core.sv =====
// i2c master bit sequencer: every input word is one bus timing tick and gives
// exactly one output word with the driven scl/sda levels, busy, a done pulse,
// the receive shift register and the last sampled ack bit.
// input channel: in_valid/in_ready with command_valid, operation, tx_byte,
// ack_to_send and the sampled sda_line. a command starts a sequence only
// while the sequencer is idle; otherwise it is dropped.
// output channel: out_valid/out_ready, one word per accepted input word.
// path: an accepted word goes into the two-entry input queue, from which the
// sequencer takes it and writes the output register.
// throughput: one word per cycle; the sequencer does one tick per cycle.
// when out_ready is low the output word holds, the sequencer stops, and the
// queue absorbs up to two more words before in_ready drops.
// each step is held for ticks_per_step ticks (apb register at 0, reset 50).
// reset: queue empty, no output word, lines released high, ack bit high.
module i2c_master_bit_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command_valid,
    input  logic [2:0]  operation,
    input  logic [7:0]  tx_byte,
    input  logic        ack_to_send,
    input  logic        sda_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        ack_seen
);

    logic [i2cms_pkg::TPS_WIDTH-1:0] tps_reg;
    i2cms_pkg::q_head_t              head;
    logic                            pop;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= i2cms_pkg::TPS_RESET;
        else if (cfg_wr && (paddr[2] == i2cms_pkg::REG_TICKS_PER_STEP))
            tps_reg <= pwdata[i2cms_pkg::TPS_WIDTH-1:0];
    end

    always_comb
    begin
        if (paddr[2] == i2cms_pkg::REG_TICKS_PER_STEP)
            prdata = 32'(tps_reg);
        else
            prdata = 32'd0;
    end

    i2cms_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command_valid (command_valid),
        .operation     (operation),
        .tx_byte       (tx_byte),
        .ack_to_send   (ack_to_send),
        .sda_line      (sda_line),
        .head          (head),
        .pop           (pop)
    );

    i2cms_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .ticks_per_step (tps_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_level      (scl_level),
        .sda_level      (sda_level),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .rx_byte        (rx_byte),
        .ack_seen       (ack_seen)
    );

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done pulse while sequence still busy");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> head.valid)
        else $error("input stalled with empty queue");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && out_valid) |-> out_ready)
        else $error("sequencer advanced over a waiting output word");
`endif

endmodule

// ===== dv/i2c_master_bit_sequencer_core_test.sv =====
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;

    // operation codes with no meaning, the sequencer must drop them
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_pick_t;
    typedef enum {RX_FREE, RX_HALF, RX_SPARSE} rx_pace_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } line_word_t;

    class line_scoreboard;
        line_word_t                         levels_q[$];
        int                                 errors;
        logic [15:0]                        ticks;
        bit                                 active;
        i2cms_pkg::op_t                     cur_op;
        logic [4:0]                         step_idx;
        logic [i2cms_pkg::HOLD_WIDTH-1:0]   hold_left;
        logic [7:0]                         tx_sh;
        logic [7:0]                         rx_sh;
        logic                               scl;
        logic                               sda;
        logic                               ack;

        function new();
            errors    = 0;
            ticks     = i2cms_pkg::TPS_RESET;
            active    = 1'b0;
            cur_op    = i2cms_pkg::OP_START;
            step_idx  = '0;
            hold_left = '0;
            tx_sh     = '0;
            rx_sh     = '0;
            scl       = 1'b1;
            sda       = 1'b1;
            ack       = 1'b1;
        endfunction

        function logic [i2cms_pkg::HOLD_WIDTH-1:0] reload();
            longint unsigned t;
            longint unsigned cap;
            t   = (ticks == 16'd0) ? 64'd1 : 64'(ticks);
            cap = (64'd1 << i2cms_pkg::HOLD_WIDTH) - 64'd1;
            t   = t - 64'd1;
            if (t > cap)
                t = cap;
            return t[i2cms_pkg::HOLD_WIDTH-1:0];
        endfunction

        function logic [4:0] steps_of(i2cms_pkg::op_t op);
            case (op)
                i2cms_pkg::OP_START:  return 5'd4;
                i2cms_pkg::OP_STOP:   return 5'd3;
                i2cms_pkg::OP_SEND:   return 5'd26;
                i2cms_pkg::OP_RECV:   return 5'd27;
                i2cms_pkg::OP_ACK_TX: return 5'd3;
                default:              return 5'd4;
            endcase
        endfunction

        function void drive_step(logic sda_in);
            int unsigned slot;
            int unsigned ph;
            case (cur_op)
                i2cms_pkg::OP_START:
                begin
                    if (step_idx == 5'd0)      sda = 1'b1;
                    else if (step_idx == 5'd1) scl = 1'b1;
                    else if (step_idx == 5'd2) sda = 1'b0;
                    else                       scl = 1'b0;
                end
                i2cms_pkg::OP_STOP:
                begin
                    if (step_idx == 5'd0)      sda = 1'b0;
                    else if (step_idx == 5'd1) scl = 1'b1;
                    else                       sda = 1'b1;
                end
                i2cms_pkg::OP_SEND:
                begin
                    if (step_idx < 5'd24)
                    begin
                        slot = int'(step_idx) / 3;
                        ph   = int'(step_idx) % 3;
                        if (ph == 0)      sda = tx_sh[7 - slot];
                        else if (ph == 1) scl = 1'b1;
                        else              scl = 1'b0;
                    end
                    else if (step_idx == 5'd24) scl = 1'b0;
                    else                        sda = 1'b1;
                end
                i2cms_pkg::OP_RECV:
                begin
                    if (step_idx == 5'd0)
                        sda = 1'b1;
                    else if (step_idx <= 5'd24)
                    begin
                        slot = (int'(step_idx) - 1) / 3;
                        ph   = (int'(step_idx) - 1) % 3;
                        if (ph == 0)      scl = 1'b1;
                        else if (ph == 1)
                        begin
                            if (sda_in)
                                rx_sh[7 - slot] = 1'b1;
                        end
                        else              scl = 1'b0;
                    end
                    else if (step_idx == 5'd25) scl = 1'b0;
                    else                        sda = 1'b1;
                end
                i2cms_pkg::OP_ACK_TX:
                begin
                    if (step_idx == 5'd0)      sda = tx_sh[7];
                    else if (step_idx == 5'd1) scl = 1'b1;
                    else                       scl = 1'b0;
                end
                default:
                begin
                    if (step_idx == 5'd0)      sda = 1'b1;
                    else if (step_idx == 5'd1) scl = 1'b1;
                    else if (step_idx == 5'd2) ack = sda_in;
                    else                       scl = 1'b0;
                end
            endcase
        endfunction

        // one bus tick: advance the sequence and queue the line levels it leaves
        function void note_tick(logic cmd, logic [2:0] op, logic [7:0] tx, logic ackb,
                                logic sda_in);
            logic       fin;
            line_word_t w;
            fin = 1'b0;
            if (active)
            begin
                if (hold_left != '0)
                    hold_left = hold_left - 1'b1;
                else
                begin
                    step_idx = step_idx + 5'd1;
                    if (step_idx >= steps_of(cur_op))
                    begin
                        active = 1'b0;
                        fin    = 1'b1;
                    end
                    else
                    begin
                        drive_step(sda_in);
                        hold_left = reload();
                    end
                end
            end
            else if (cmd && op <= i2cms_pkg::OP_ACK_RX)
            begin
                active   = 1'b1;
                cur_op   = i2cms_pkg::op_t'(op);
                step_idx = '0;
                if (cur_op == i2cms_pkg::OP_ACK_TX)
                    tx_sh = {ackb, 7'd0};
                else if (cur_op == i2cms_pkg::OP_SEND)
                    tx_sh = tx;
                if (cur_op == i2cms_pkg::OP_RECV)
                    rx_sh = '0;
                drive_step(sda_in);
                hold_left = reload();
            end
            w.scl  = scl;
            w.sda  = sda;
            w.busy = active;
            w.done = fin;
            w.rx   = rx_sh;
            w.ack  = ack;
            levels_q.push_back(w);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(line_word_t got);
            line_word_t want;
            if (levels_q.size() == 0)
            begin
                $display("%0t: output word with none expected, got %h", $time, got);
                errors++;
                return;
            end
            want = levels_q.pop_front();
            field_check("scl_level", 8'(want.scl), 8'(got.scl));
            field_check("sda_level", 8'(want.sda), 8'(got.sda));
            field_check("busy_res", 8'(want.busy), 8'(got.busy));
            field_check("done_res", 8'(want.done), 8'(got.done));
            field_check("rx_byte", want.rx, got.rx);
            field_check("ack_seen", 8'(want.ack), 8'(got.ack));
        endfunction

        function int pending();
            return levels_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        command_valid;
    logic [2:0]  operation;
    logic [7:0]  tx_byte;
    logic        ack_to_send;
    logic        sda_line;
    logic        out_valid;
    logic        out_ready;
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_seen;

    line_scoreboard sb;
    line_word_t     out_word;
    int             burst_left;
    int             cmds_started;
    int             idle_cycles;
    bit             rx_hold_req;
    int             rx_hold_cnt;
    int             rx_seg_left;
    rx_pace_t       rx_pace;

    i2c_master_bit_sequencer_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic pick_sda(sda_pick_t pick);
        case (pick)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // offer one tick word and hold it until taken, then maybe open a gap
    task automatic push_tick(input logic cmd, input logic [2:0] op, input logic [7:0] tx,
                             input logic ackb, input logic sda_in);
        @(negedge clk);
        in_valid      <= 1'b1;
        command_valid <= cmd;
        operation     <= op;
        tx_byte       <= tx;
        ack_to_send   <= ackb;
        sda_line      <= sda_in;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(cmd, op, tx, ackb, sda_in);
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 5))
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
    endtask

    // issue a command, then keep ticking with junk commands until it finishes
    task automatic run_cmd(input i2cms_pkg::op_t op, input logic [7:0] tx, input logic ackb,
                           input sda_pick_t pick);
        push_tick(1'b1, op, tx, ackb, pick_sda(pick));
        while (sb.active)
            push_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), pick_sda(pick));
    endtask

    task automatic settle();
        while (sb.active)
            push_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_ticks(input logic [15:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {i2cms_pkg::REG_TICKS_PER_STEP, 2'b00};
        pwdata  <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.ticks = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_tick();
        logic       cmd;
        logic [2:0] op;
        int         r;
        if (!sb.active)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
            begin
                cmd = 1'b1;
                op  = 3'($urandom_range(0, 5));
            end
            else if (r < 91)
            begin
                cmd = 1'b1;
                op  = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
            end
            else
            begin
                cmd = 1'b0;
                op  = 3'($urandom_range(0, 7));
            end
            if (cmd && op <= i2cms_pkg::OP_ACK_RX)
                cmds_started++;
        end
        else
        begin
            cmd = ($urandom_range(0, 3) == 0);
            op  = 3'($urandom_range(0, 7));
        end
        push_tick(cmd, op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input logic [15:0] val, input int n_cmds, input bit long_hold);
        int first;
        bit hold_sent;
        first     = cmds_started;
        hold_sent = 1'b0;
        write_ticks(val);
        while (cmds_started - first < n_cmds)
        begin
            if (long_hold && !hold_sent && cmds_started - first >= n_cmds / 2)
            begin
                rx_hold_req = 1'b1;
                hold_sent   = 1'b1;
            end
            random_tick();
        end
        settle();
        quiesce();
    endtask

    // receiver: segments of free, half and sparse ready, plus one long hold-off on request
    initial
    begin
        out_ready   = 1'b0;
        rx_hold_cnt = 0;
        rx_seg_left = 0;
        rx_pace     = RX_FREE;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_hold_cnt = LONG_HOLD;
            end
            if (rx_seg_left == 0)
            begin
                rx_seg_left = $urandom_range(20, 200);
                rx_pace     = rx_pace_t'($urandom_range(0, 2));
            end
            rx_seg_left--;
            if (rx_hold_cnt != 0)
            begin
                rx_hold_cnt--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_pace)
                    RX_FREE:  out_ready <= 1'b1;
                    RX_HALF:  out_ready <= 1'($urandom_range(0, 1));
                    default:  out_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_word.scl  = scl_level;
            out_word.sda  = sda_level;
            out_word.busy = busy_res;
            out_word.done = done_res;
            out_word.rx   = rx_byte;
            out_word.ack  = ack_seen;
            sb.check_word(out_word);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        command_valid = 1'b0;
        operation     = i2cms_pkg::OP_START;
        tx_byte       = '0;
        ack_to_send   = 1'b0;
        sda_line      = 1'b1;
        burst_left    = 1;
        cmds_started  = 0;
        rx_hold_req   = 1'b0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset hold of 50 ticks per step
        run_cmd(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RAND);
        quiesce();

        write_ticks(16'd1);
        run_cmd(i2cms_pkg::OP_START, 8'h00, 1'b1, SDA_RAND);
        run_cmd(i2cms_pkg::OP_SEND, 8'hFF, 1'b0, SDA_RAND);
        run_cmd(i2cms_pkg::OP_SEND, 8'h00, 1'b1, SDA_RAND);
        run_cmd(i2cms_pkg::OP_SEND, 8'hA5, 1'b0, SDA_RAND);
        run_cmd(i2cms_pkg::OP_SEND, 8'h5A, 1'b1, SDA_RAND);
        run_cmd(i2cms_pkg::OP_ACK_RX, 8'h00, 1'b0, SDA_LOW);
        run_cmd(i2cms_pkg::OP_ACK_RX, 8'hFF, 1'b1, SDA_HIGH);
        run_cmd(i2cms_pkg::OP_RECV, 8'h00, 1'b0, SDA_HIGH);
        run_cmd(i2cms_pkg::OP_RECV, 8'hFF, 1'b1, SDA_LOW);
        run_cmd(i2cms_pkg::OP_RECV, 8'h3C, 1'b0, SDA_RAND);
        run_cmd(i2cms_pkg::OP_ACK_TX, 8'hFF, 1'b0, SDA_RAND);
        run_cmd(i2cms_pkg::OP_ACK_TX, 8'h00, 1'b1, SDA_RAND);
        push_tick(1'b1, OP_UNUSED_6, 8'hFF, 1'b1, 1'b0);
        push_tick(1'b1, OP_UNUSED_7, 8'h00, 1'b0, 1'b1);
        push_tick(1'b0, i2cms_pkg::OP_SEND, 8'h81, 1'b1, 1'b1);
        run_cmd(i2cms_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND);
        quiesce();

        // zero hold behaves as one tick
        write_ticks(16'd0);
        run_cmd(i2cms_pkg::OP_SEND, 8'($urandom_range(0, 255)), 1'b0, SDA_RAND);
        run_cmd(i2cms_pkg::OP_ACK_RX, 8'h00, 1'b0, SDA_RAND);
        quiesce();

        run_phase(16'd1, 20, 1'b0);
        run_phase(16'd2, 12, 1'b1);
        run_phase(16'd0, 12, 1'b0);
        run_phase(16'd3, 6, 1'b0);

        repeat (8)
            @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d output words expected but never seen", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/i2cms_pkg.sv
sv/i2cms_front.sv
sv/i2cms_back.sv
sv/i2c_master_bit_sequencer_core.sv
dv/i2c_master_bit_sequencer_core_test.sv
